>>> rtl/dichromat_confusion_line_projection_unit_macros.svh
// ---------------------------------------------------------------------------
// dichromat confusion line projection unit - assertion macros
// clocked property wrappers used by the checker file
// ---------------------------------------------------------------------------
`ifndef DICHROMAT_CONFUSION_LINE_PROJECTION_UNIT_MACROS_SVH
`define DICHROMAT_CONFUSION_LINE_PROJECTION_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PDCL_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdcl assertion failed");

// next-cycle implication, disabled in reset
`define PDCL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdcl assertion failed");

`endif

>>> rtl/pdcl_pkg.sv
// ---------------------------------------------------------------------------
// pdcl_pkg
// shared types, codes and saturation helpers of the projection unit
// ---------------------------------------------------------------------------
package pdcl_pkg;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PARALLEL = 2'd1;
    localparam logic [1:0] ST_DEGEN    = 2'd2;
    localparam logic [1:0] ST_SAT      = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_CONFUSION_U   = 2'd0;
    localparam logic [1:0] CFG_CONFUSION_V   = 2'd1;
    localparam logic [1:0] CFG_AXIS_SLOPE    = 2'd2;
    localparam logic [1:0] CFG_AXIS_INTERCEPT = 2'd3;

    // reset values, deuteranopia
    localparam logic signed [31:0] CONFUSION_U_RST    = -32'sd79691776;
    localparam logic signed [31:0] CONFUSION_V_RST    = 32'sd21978153;
    localparam logic signed [31:0] AXIS_SLOPE_RST     = 32'sd36159598;
    localparam logic signed [31:0] AXIS_INTERCEPT_RST = 32'sd165366;

    localparam logic [23:0] OUT_MAX = 24'hFFFFFF;

    // control word that travels with every item
    typedef struct packed {
        logic       valid;
        logic       done;
        logic [1:0] st;
        logic       clip;
    } ctl_t;

    function automatic logic ovf32(input logic signed [63:0] v);
        return (v > 64'sd2147483647) || (v < -64'sd2147483648);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

    function automatic logic [31:0] abs33(input logic signed [32:0] v);
        logic [32:0] r;
        r = v[32] ? 33'(-v) : 33'(v);
        return r[31:0];
    endfunction

endpackage

>>> rtl/pdcl_cfg.sv
// ---------------------------------------------------------------------------
// pdcl_cfg
// confusion point and dichromat axis registers
// ---------------------------------------------------------------------------
module pdcl_cfg
    import pdcl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic signed [31:0] confusion_u,
    output logic signed [31:0] confusion_v,
    output logic signed [31:0] axis_slope,
    output logic signed [31:0] axis_intercept
);

    logic signed [31:0] cu_reg;
    logic signed [31:0] cv_reg;
    logic signed [31:0] as_reg;
    logic signed [31:0] ai_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cu_reg <= CONFUSION_U_RST;
            cv_reg <= CONFUSION_V_RST;
            as_reg <= AXIS_SLOPE_RST;
            ai_reg <= AXIS_INTERCEPT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CONFUSION_U:    cu_reg <= cfg_data;
                CFG_CONFUSION_V:    cv_reg <= cfg_data;
                CFG_AXIS_SLOPE:     as_reg <= cfg_data;
                CFG_AXIS_INTERCEPT: ai_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign confusion_u    = cu_reg;
    assign confusion_v    = cv_reg;
    assign axis_slope     = as_reg;
    assign axis_intercept = ai_reg;

endmodule

>>> rtl/pdcl_div.sv
// ---------------------------------------------------------------------------
// pdcl_div
// pipelined restoring divider, one quotient bit per stage, with sideband
// ---------------------------------------------------------------------------
module pdcl_div #(
    parameter int NW = 52,
    parameter int DW = 29,
    parameter int SW = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [NW-1:0] num_in,
    input  logic [DW-1:0] den_in,
    input  logic [SW-1:0] side_in,
    output logic [NW-1:0] quo_out,
    output logic [SW-1:0] side_out
);

    logic [DW-1:0] rem_reg  [NW];
    logic [NW-1:0] nq_reg   [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [SW-1:0] side_reg [NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        logic [DW-1:0] rem_i;
        logic [NW-1:0] nq_i;
        logic [DW-1:0] den_i;
        logic [SW-1:0] side_i;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rem_i  = '0;
            assign nq_i   = num_in;
            assign den_i  = den_in;
            assign side_i = side_in;
        end
        else
        begin : g_next
            assign rem_i  = rem_reg[k-1];
            assign nq_i   = nq_reg[k-1];
            assign den_i  = den_reg[k-1];
            assign side_i = side_reg[k-1];
        end

        // shift in the next numerator bit, subtract when it fits
        assign trial = {rem_i, nq_i[NW-1]};
        assign diff  = trial - {1'b0, den_i};
        assign ge    = trial >= {1'b0, den_i};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                nq_reg[k]  <= {nq_i[NW-2:0], ge};
                den_reg[k] <= den_i;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                side_reg[k] <= '0;
            else if (en)
                side_reg[k] <= side_i;
        end
    end

    assign quo_out  = nq_reg[NW-1];
    assign side_out = side_reg[NW-1];

endmodule

>>> rtl/dichromat_confusion_line_projection_unit.sv
// ---------------------------------------------------------------------------
// dichromat_confusion_line_projection_unit
// dichromat simulation by projecting an xyz colour along its confusion line
// ---------------------------------------------------------------------------
// One XYZ item enters per clock and one simulated XYZ item leaves per clock
// when the output side does not stall. The pipeline is made of four
// bit-serial division chains in a row: u'v' (52 stages), the
// confusion line slope (56), the axis intersection (56) and the final X and Z
// (61), plus 18 stages of add, saturate and multiply around them. The whole
// pipeline advances together: it freezes only while a result sits in the
// output register and the output stalls, so in_stall is that condition. The
// confusion point and axis registers are read live where used; write
// them only while no item is in flight. Status 1 and 2 results are black,
// status 3 marks an item where an intermediate or output value clipped.
// ---------------------------------------------------------------------------
module dichromat_confusion_line_projection_unit
    import pdcl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [23:0] x_in,
    input  logic [23:0] y_in,
    input  logic [23:0] z_in,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] x_out,
    output logic [23:0] y_out,
    output logic [23:0] z_out,
    output logic [1:0]  status,
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CW = $bits(ctl_t);

    logic signed [31:0] cu;
    logic signed [31:0] cv;
    logic signed [31:0] as;
    logic signed [31:0] ai;

    // global advance: every stage moves unless a result is held at the port
    logic adv;

    pdcl_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .confusion_u    (cu),
        .confusion_v    (cv),
        .axis_slope     (as),
        .axis_intercept (ai)
    );

    // ------------------------------------------------------------------
    // p0: denominator x + 15y + 3z and the scaled u'v' numerators
    // ------------------------------------------------------------------
    logic [28:0] d_sum;
    logic [27:0] y9;
    ctl_t        p0_ctl_reg, p0_ctl_next;
    logic [23:0] p0_y_reg;
    logic [28:0] p0_d_reg;
    logic [51:0] p0_nu_reg;
    logic [51:0] p0_nv_reg;

    always_comb
    begin
        d_sum = {5'b0, x_in} + {1'b0, y_in, 4'b0} - {5'b0, y_in}
              + {4'b0, z_in, 1'b0} + {5'b0, z_in};
        y9    = {4'b0, y_in} + {1'b0, y_in, 3'b0};
        p0_ctl_next.valid = in_valid;
        p0_ctl_next.done  = (d_sum == 29'd0);
        p0_ctl_next.st    = ST_DEGEN;
        p0_ctl_next.clip  = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p0_ctl_reg <= '0;
        else if (adv)
            p0_ctl_reg <= p0_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_y_reg  <= y_in;
            p0_d_reg  <= d_sum;
            p0_nu_reg <= {2'b0, x_in, 26'b0};
            p0_nv_reg <= {y9, 24'b0};
        end
    end

    // u' = 4x*2^24/d and v' = 9y*2^24/d
    logic [51:0] qa_u;
    logic [51:0] qa_v;
    ctl_t        a_ctl;
    logic [23:0] a_y;

    pdcl_div #(.NW(52), .DW(29), .SW(CW)) u_div_u (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .num_in   (p0_nu_reg),
        .den_in   (p0_d_reg),
        .side_in  (p0_ctl_reg),
        .quo_out  (qa_u),
        .side_out (a_ctl)
    );

    pdcl_div #(.NW(52), .DW(29), .SW(24)) u_div_v (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .num_in   (p0_nv_reg),
        .den_in   (p0_d_reg),
        .side_in  (p0_y_reg),
        .quo_out  (qa_v),
        .side_out (a_y)
    );

    // ------------------------------------------------------------------
    // p1: offsets from the confusion point, saturated
    // ------------------------------------------------------------------
    logic signed [63:0] du_w;
    logic signed [63:0] dv_w;
    ctl_t               p1_ctl_reg, p1_ctl_next;
    logic signed [31:0] p1_du_reg;
    logic signed [31:0] p1_dv_reg;
    logic [23:0]        p1_y_reg;

    always_comb
    begin
        du_w = $signed({12'b0, qa_u}) - 64'(cu);
        dv_w = $signed({12'b0, qa_v}) - 64'(cv);
        p1_ctl_next      = a_ctl;
        p1_ctl_next.clip = a_ctl.clip | ovf32(du_w) | ovf32(dv_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_ctl_reg <= '0;
        else if (adv)
            p1_ctl_reg <= p1_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_du_reg <= sat32(du_w);
            p1_dv_reg <= sat32(dv_w);
            p1_y_reg  <= a_y;
        end
    end

    // ------------------------------------------------------------------
    // p2: vertical line check, magnitudes for the slope division
    // ------------------------------------------------------------------
    ctl_t        p2_ctl_reg, p2_ctl_next;
    logic [55:0] p2_num_reg;
    logic [31:0] p2_den_reg;
    logic        p2_sgn_reg;
    logic [23:0] p2_y_reg;

    always_comb
    begin
        p2_ctl_next = p1_ctl_reg;
        if (!p1_ctl_reg.done && p1_du_reg == 32'sd0)
        begin
            p2_ctl_next.done = 1'b1;
            p2_ctl_next.st   = ST_DEGEN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_ctl_reg <= '0;
        else if (adv)
            p2_ctl_reg <= p2_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_num_reg <= {abs32(p1_dv_reg), 24'b0};
            p2_den_reg <= abs32(p1_du_reg);
            p2_sgn_reg <= p1_dv_reg[31] ^ p1_du_reg[31];
            p2_y_reg   <= p1_y_reg;
        end
    end

    // slope a2 = dv*2^24/du
    logic [55:0] qb;
    ctl_t        b_ctl;
    logic        b_sgn;
    logic [23:0] b_y;

    pdcl_div #(.NW(56), .DW(32), .SW(CW + 25)) u_div_slope (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .num_in   (p2_num_reg),
        .den_in   (p2_den_reg),
        .side_in  ({p2_ctl_reg, p2_sgn_reg, p2_y_reg}),
        .quo_out  (qb),
        .side_out ({b_ctl, b_sgn, b_y})
    );

    // ------------------------------------------------------------------
    // p3: signed slope, saturated
    // ------------------------------------------------------------------
    logic signed [63:0] a_w;
    ctl_t               p3_ctl_reg, p3_ctl_next;
    logic signed [31:0] p3_a2_reg;
    logic [23:0]        p3_y_reg;

    always_comb
    begin
        a_w = b_sgn ? -$signed({8'b0, qb}) : $signed({8'b0, qb});
        p3_ctl_next      = b_ctl;
        p3_ctl_next.clip = b_ctl.clip | ovf32(a_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_ctl_reg <= '0;
        else if (adv)
            p3_ctl_reg <= p3_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_a2_reg <= sat32(a_w);
            p3_y_reg  <= b_y;
        end
    end

    // ------------------------------------------------------------------
    // p4: parallel check, a2*cu product, intersection denominator
    // ------------------------------------------------------------------
    ctl_t               p4_ctl_reg, p4_ctl_next;
    logic signed [63:0] p4_prod_reg;
    logic signed [32:0] p4_dens_reg;
    logic [23:0]        p4_y_reg;

    always_comb
    begin
        p4_ctl_next = p3_ctl_reg;
        if (!p3_ctl_reg.done && p3_a2_reg == as)
        begin
            p4_ctl_next.done = 1'b1;
            p4_ctl_next.st   = ST_PARALLEL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p4_ctl_reg <= '0;
        else if (adv)
            p4_ctl_reg <= p4_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p4_prod_reg <= p3_a2_reg * cu;
            p4_dens_reg <= 33'(as) - 33'(p3_a2_reg);
            p4_y_reg    <= p3_y_reg;
        end
    end

    // ------------------------------------------------------------------
    // p5: product / 2^24 rounded toward zero
    // ------------------------------------------------------------------
    logic signed [63:0] t_w;
    ctl_t               p5_ctl_reg;
    logic signed [39:0] p5_t_reg;
    logic signed [32:0] p5_dens_reg;
    logic [23:0]        p5_y_reg;

    assign t_w = (p4_prod_reg + (p4_prod_reg[63] ? 64'sd16777215 : 64'sd0)) >>> 24;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p5_ctl_reg <= '0;
        else if (adv)
            p5_ctl_reg <= p4_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p5_t_reg    <= t_w[39:0];
            p5_dens_reg <= p4_dens_reg;
            p5_y_reg    <= p4_y_reg;
        end
    end

    // ------------------------------------------------------------------
    // p6: line intercept b2 = cv - a2*cu/2^24, saturated
    // ------------------------------------------------------------------
    logic signed [63:0] b2_w;
    ctl_t               p6_ctl_reg, p6_ctl_next;
    logic signed [31:0] p6_b2_reg;
    logic signed [32:0] p6_dens_reg;
    logic [23:0]        p6_y_reg;

    always_comb
    begin
        b2_w = 64'(cv) - 64'(p5_t_reg);
        p6_ctl_next      = p5_ctl_reg;
        p6_ctl_next.clip = p5_ctl_reg.clip | ovf32(b2_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p6_ctl_reg <= '0;
        else if (adv)
            p6_ctl_reg <= p6_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p6_b2_reg   <= sat32(b2_w);
            p6_dens_reg <= p5_dens_reg;
            p6_y_reg    <= p5_y_reg;
        end
    end

    // ------------------------------------------------------------------
    // p7: intersection numerator b2 - intercept
    // ------------------------------------------------------------------
    ctl_t               p7_ctl_reg;
    logic signed [32:0] p7_nums_reg;
    logic signed [32:0] p7_dens_reg;
    logic [23:0]        p7_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p7_ctl_reg <= '0;
        else if (adv)
            p7_ctl_reg <= p6_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p7_nums_reg <= 33'(p6_b2_reg) - 33'(ai);
            p7_dens_reg <= p6_dens_reg;
            p7_y_reg    <= p6_y_reg;
        end
    end

    // ------------------------------------------------------------------
    // p8: magnitudes for the intersection division
    // ------------------------------------------------------------------
    ctl_t        p8_ctl_reg;
    logic [55:0] p8_num_reg;
    logic [31:0] p8_den_reg;
    logic        p8_sgn_reg;
    logic [23:0] p8_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p8_ctl_reg <= '0;
        else if (adv)
            p8_ctl_reg <= p7_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p8_num_reg <= {abs33(p7_nums_reg), 24'b0};
            p8_den_reg <= abs33(p7_dens_reg);
            p8_sgn_reg <= p7_nums_reg[32] ^ p7_dens_reg[32];
            p8_y_reg   <= p7_y_reg;
        end
    end

    // pu = (b2 - intercept)*2^24/(slope - a2)
    logic [55:0] qc;
    ctl_t        c_ctl;
    logic        c_sgn;
    logic [23:0] c_y;

    pdcl_div #(.NW(56), .DW(32), .SW(CW + 25)) u_div_isect (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .num_in   (p8_num_reg),
        .den_in   (p8_den_reg),
        .side_in  ({p8_ctl_reg, p8_sgn_reg, p8_y_reg}),
        .quo_out  (qc),
        .side_out ({c_ctl, c_sgn, c_y})
    );

    // ------------------------------------------------------------------
    // p9: signed pu, saturated
    // ------------------------------------------------------------------
    logic signed [63:0] pu_w;
    ctl_t               p9_ctl_reg, p9_ctl_next;
    logic signed [31:0] p9_pu_reg;
    logic [23:0]        p9_y_reg;

    always_comb
    begin
        pu_w = c_sgn ? -$signed({8'b0, qc}) : $signed({8'b0, qc});
        p9_ctl_next      = c_ctl;
        p9_ctl_next.clip = c_ctl.clip | ovf32(pu_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p9_ctl_reg <= '0;
        else if (adv)
            p9_ctl_reg <= p9_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p9_pu_reg <= sat32(pu_w);
            p9_y_reg  <= c_y;
        end
    end

    // ------------------------------------------------------------------
    // p10: slope * pu
    // ------------------------------------------------------------------
    ctl_t               p10_ctl_reg;
    logic signed [63:0] p10_prod_reg;
    logic signed [31:0] p10_pu_reg;
    logic [23:0]        p10_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p10_ctl_reg <= '0;
        else if (adv)
            p10_ctl_reg <= p9_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p10_prod_reg <= as * p9_pu_reg;
            p10_pu_reg   <= p9_pu_reg;
            p10_y_reg    <= p9_y_reg;
        end
    end

    // ------------------------------------------------------------------
    // p11: product / 2^24 rounded toward zero
    // ------------------------------------------------------------------
    logic signed [63:0] t2_w;
    ctl_t               p11_ctl_reg;
    logic signed [39:0] p11_t_reg;
    logic signed [31:0] p11_pu_reg;
    logic [23:0]        p11_y_reg;

    assign t2_w = (p10_prod_reg + (p10_prod_reg[63] ? 64'sd16777215 : 64'sd0)) >>> 24;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p11_ctl_reg <= '0;
        else if (adv)
            p11_ctl_reg <= p10_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p11_t_reg  <= t2_w[39:0];
            p11_pu_reg <= p10_pu_reg;
            p11_y_reg  <= p10_y_reg;
        end
    end

    // ------------------------------------------------------------------
    // p12: pv on the axis, saturated
    // ------------------------------------------------------------------
    logic signed [63:0] pv_w;
    ctl_t               p12_ctl_reg, p12_ctl_next;
    logic signed [31:0] p12_pv_reg;
    logic signed [31:0] p12_pu_reg;
    logic [23:0]        p12_y_reg;

    always_comb
    begin
        pv_w = 64'(p11_t_reg) + 64'(ai);
        p12_ctl_next      = p11_ctl_reg;
        p12_ctl_next.clip = p11_ctl_reg.clip | ovf32(pv_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p12_ctl_reg <= '0;
        else if (adv)
            p12_ctl_reg <= p12_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p12_pv_reg <= sat32(pv_w);
            p12_pu_reg <= p11_pu_reg;
            p12_y_reg  <= p11_y_reg;
        end
    end

    // ------------------------------------------------------------------
    // p13: zero pv check, 9pu, 3pu and 20pv terms
    // ------------------------------------------------------------------
    ctl_t               p13_ctl_reg, p13_ctl_next;
    logic signed [35:0] p13_m_reg;
    logic signed [33:0] p13_s1_reg;
    logic signed [36:0] p13_s2_reg;
    logic [31:0]        p13_mpv_reg;
    logic               p13_pvs_reg;
    logic [23:0]        p13_y_reg;

    always_comb
    begin
        p13_ctl_next = p12_ctl_reg;
        if (!p12_ctl_reg.done && p12_pv_reg == 32'sd0)
        begin
            p13_ctl_next.done = 1'b1;
            p13_ctl_next.st   = ST_DEGEN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p13_ctl_reg <= '0;
        else if (adv)
            p13_ctl_reg <= p13_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p13_m_reg   <= (36'(p12_pu_reg) <<< 3) + 36'(p12_pu_reg);
            p13_s1_reg  <= (34'(p12_pu_reg) <<< 1) + 34'(p12_pu_reg);
            p13_s2_reg  <= (37'(p12_pv_reg) <<< 4) + (37'(p12_pv_reg) <<< 2);
            p13_mpv_reg <= abs32(p12_pv_reg);
            p13_pvs_reg <= p12_pv_reg[31];
            p13_y_reg   <= p12_y_reg;
        end
    end

    // ------------------------------------------------------------------
    // p14: w = 12*2^24 - 3pu - 20pv, magnitude of 9pu
    // ------------------------------------------------------------------
    logic signed [35:0] m_abs_w;
    ctl_t               p14_ctl_reg;
    logic signed [37:0] p14_w_reg;
    logic [34:0]        p14_mm_reg;
    logic               p14_sm_reg;
    logic [31:0]        p14_mpv_reg;
    logic               p14_pvs_reg;
    logic [23:0]        p14_y_reg;

    assign m_abs_w = p13_m_reg[35] ? -p13_m_reg : p13_m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p14_ctl_reg <= '0;
        else if (adv)
            p14_ctl_reg <= p13_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p14_w_reg   <= 38'sd201326592 - 38'(p13_s1_reg) - 38'(p13_s2_reg);
            p14_mm_reg  <= m_abs_w[34:0];
            p14_sm_reg  <= p13_m_reg[35];
            p14_mpv_reg <= p13_mpv_reg;
            p14_pvs_reg <= p13_pvs_reg;
            p14_y_reg   <= p13_y_reg;
        end
    end

    // ------------------------------------------------------------------
    // p15: magnitude of w
    // ------------------------------------------------------------------
    logic signed [37:0] w_abs_w;
    ctl_t               p15_ctl_reg;
    logic [36:0]        p15_mw_reg;
    logic               p15_sw_reg;
    logic [34:0]        p15_mm_reg;
    logic               p15_sm_reg;
    logic [31:0]        p15_mpv_reg;
    logic               p15_pvs_reg;
    logic [23:0]        p15_y_reg;

    assign w_abs_w = p14_w_reg[37] ? -p14_w_reg : p14_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p15_ctl_reg <= '0;
        else if (adv)
            p15_ctl_reg <= p14_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p15_mw_reg  <= w_abs_w[36:0];
            p15_sw_reg  <= p14_w_reg[37];
            p15_mm_reg  <= p14_mm_reg;
            p15_sm_reg  <= p14_sm_reg;
            p15_mpv_reg <= p14_mpv_reg;
            p15_pvs_reg <= p14_pvs_reg;
            p15_y_reg   <= p14_y_reg;
        end
    end

    // ------------------------------------------------------------------
    // p16: y*9pu and y*w, divisor 4|pv|
    // ------------------------------------------------------------------
    logic [58:0] px_w;
    logic [60:0] pz_w;
    ctl_t        p16_ctl_reg;
    logic [60:0] p16_px_reg;
    logic [60:0] p16_pz_reg;
    logic [33:0] p16_den_reg;
    logic        p16_sx_reg;
    logic        p16_sz_reg;
    logic [23:0] p16_y_reg;

    assign px_w = p15_y_reg * p15_mm_reg;
    assign pz_w = p15_y_reg * p15_mw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p16_ctl_reg <= '0;
        else if (adv)
            p16_ctl_reg <= p15_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p16_px_reg  <= 61'(px_w);
            p16_pz_reg  <= pz_w;
            p16_den_reg <= {p15_mpv_reg, 2'b0};
            p16_sx_reg  <= p15_sm_reg ^ p15_pvs_reg;
            p16_sz_reg  <= p15_sw_reg ^ p15_pvs_reg;
            p16_y_reg   <= p15_y_reg;
        end
    end

    // x = y*9pu/(4pv), z = y*w/(4pv)
    logic [60:0] qx;
    logic [60:0] qz;
    ctl_t        e_ctl;
    logic        e_sx;
    logic        e_sz;
    logic [23:0] e_y;

    pdcl_div #(.NW(61), .DW(34), .SW(CW + 2)) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .num_in   (p16_px_reg),
        .den_in   (p16_den_reg),
        .side_in  ({p16_ctl_reg, p16_sx_reg, p16_sz_reg}),
        .quo_out  (qx),
        .side_out ({e_ctl, e_sx, e_sz})
    );

    pdcl_div #(.NW(61), .DW(34), .SW(24)) u_div_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .num_in   (p16_pz_reg),
        .den_in   (p16_den_reg),
        .side_in  (p16_y_reg),
        .quo_out  (qz),
        .side_out (e_y)
    );

    // ------------------------------------------------------------------
    // output register: clamp to 0..2^24-1, black on special cases
    // ------------------------------------------------------------------
    logic        out_valid_reg;
    logic [23:0] x_out_reg, x_out_next;
    logic [23:0] y_out_reg, y_out_next;
    logic [23:0] z_out_reg, z_out_next;
    logic [1:0]  status_reg, status_next;
    logic        clip_x;
    logic        clip_z;
    logic [23:0] x_clamp;
    logic [23:0] z_clamp;

    always_comb
    begin
        // a negative nonzero quotient clamps to 0, a large one to full scale
        clip_x  = 1'b0;
        x_clamp = qx[23:0];
        if (e_sx && qx != 61'd0)
        begin
            clip_x  = 1'b1;
            x_clamp = 24'd0;
        end
        else if (qx > 61'(OUT_MAX))
        begin
            clip_x  = 1'b1;
            x_clamp = OUT_MAX;
        end

        clip_z  = 1'b0;
        z_clamp = qz[23:0];
        if (e_sz && qz != 61'd0)
        begin
            clip_z  = 1'b1;
            z_clamp = 24'd0;
        end
        else if (qz > 61'(OUT_MAX))
        begin
            clip_z  = 1'b1;
            z_clamp = OUT_MAX;
        end

        if (e_ctl.done)
        begin
            x_out_next  = 24'd0;
            y_out_next  = 24'd0;
            z_out_next  = 24'd0;
            status_next = e_ctl.st;
        end
        else
        begin
            x_out_next  = x_clamp;
            y_out_next  = e_y;
            z_out_next  = z_clamp;
            status_next = (e_ctl.clip || clip_x || clip_z) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= e_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_out_reg  <= x_out_next;
            y_out_reg  <= y_out_next;
            z_out_reg  <= z_out_next;
            status_reg <= status_next;
        end
    end

    assign adv       = !(out_valid_reg && out_stall);
    assign in_stall  = !adv;
    assign out_valid = out_valid_reg;
    assign x_out     = x_out_reg;
    assign y_out     = y_out_reg;
    assign z_out     = z_out_reg;
    assign status    = status_reg;

endmodule

>>> rtl/pdcl_chk.sv
// ---------------------------------------------------------------------------
// pdcl_chk
// port-level checks of the projection unit, bound to the top level
// ---------------------------------------------------------------------------
`include "dichromat_confusion_line_projection_unit_macros.svh"

module pdcl_chk
    import pdcl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [23:0] x_out,
    input logic [23:0] y_out,
    input logic [23:0] z_out,
    input logic [1:0]  status
);

    // parallel lines and degenerate input give black
    `PDCL_ASSERT_IMP(a_black_special, out_valid && (status == ST_PARALLEL || status == ST_DEGEN), x_out == 24'd0 && y_out == 24'd0 && z_out == 24'd0)

    // the input only stalls behind a held result
    `PDCL_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

    // a stalled result holds
    `PDCL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(x_out) && $stable(y_out) && $stable(z_out) && $stable(status))

endmodule

bind dichromat_confusion_line_projection_unit pdcl_chk u_pdcl_chk (.*);
